@@ design/color_temperature_pixel_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Color temperature pixel unit - assertion macros
// Concurrent assertion helpers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_PIXEL_UNIT_ASSERT_SVH
`define COLOR_TEMPERATURE_PIXEL_UNIT_ASSERT_SVH

// same-cycle implication
`define CTP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay
`define CTP_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ design/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared constants and pixel types of the color temperature pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

    localparam int CHAN_W      = 8;
    localparam int ADJ_W       = 9;
    localparam int SHIFT_W     = 9;
    localparam int FULL_SCALE  = 65280;
    localparam int WEIGHT_BASE = 256;
    localparam int RB_SHIFT    = 15;
    localparam int G_SHIFT     = 17;
    localparam int CHAN_MAX    = 255;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
    } ctp_pix_t;

    // adjusted channels, clamped at zero, may exceed 255
    typedef struct packed {
        logic [ADJ_W-1:0]  r;
        logic [ADJ_W-1:0]  g;
        logic [ADJ_W-1:0]  b;
        logic [CHAN_W-1:0] a;
    } ctp_adj_t;

    // rescale info from the reciprocal stages
    typedef struct packed {
        logic              over;
        logic [CHAN_W-1:0] inv;
    } ctp_rescale_t;

endpackage

`default_nettype wire

@@ design/ctp_adjust.sv @@
// ----------------------------------------------------------------------------
// ctp_adjust
// Stages 1-3: channel weight, weight times shift, shifted add with low clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_adjust (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire ctp_pkg::ctp_pix_t                 in_pix,
    input  wire logic signed [ctp_pkg::SHIFT_W-1:0] ts,
    output logic                                   out_valid,
    output ctp_pkg::ctp_adj_t                      out_adj
);
    import ctp_pkg::*;

    function automatic logic [14:0] weight(input logic [CHAN_W-1:0] c);
        logic [16:0] p;
        p = {9'b0, c} * (17'(WEIGHT_BASE) - {9'b0, c});
        return p[14:0];
    endfunction

    // stage 1
    logic                      v1_reg;
    ctp_pix_t                  pix1_reg;
    logic [14:0]               wr1_reg, wg1_reg, wb1_reg;
    logic signed [SHIFT_W-1:0] ts1_reg;

    // stage 2
    logic               v2_reg;
    ctp_pix_t           pix2_reg;
    logic signed [24:0] pr2_reg, pb2_reg;
    logic [22:0]        pg2_reg;

    logic signed [24:0] pr2_next, pb2_next;
    logic [22:0]        pg2_next;
    logic [7:0]         gs;

    // stage 3
    logic     v3_reg;
    ctp_adj_t adj3_reg;
    ctp_adj_t adj3_next;

    logic signed [24:0] sh_r, sh_b;
    logic [22:0]        sh_g;
    logic signed [10:0] nr, nb;

    always_comb
    begin
        gs       = ts1_reg[SHIFT_W-1] ? 8'd0 : ts1_reg[7:0];
        pr2_next = $signed({1'b0, wr1_reg}) * ts1_reg;
        pb2_next = $signed({1'b0, wb1_reg}) * ts1_reg;
        pg2_next = wg1_reg * gs;
    end

    always_comb
    begin
        sh_r = pr2_reg >>> RB_SHIFT;
        sh_b = pb2_reg >>> RB_SHIFT;
        sh_g = pg2_reg >> G_SHIFT;
        nr   = $signed({3'b0, pix2_reg.r}) + $signed(sh_r[10:0]);
        nb   = $signed({3'b0, pix2_reg.b}) - $signed(sh_b[10:0]);
        adj3_next.r = nr[10] ? 9'd0 : nr[8:0];
        adj3_next.b = nb[10] ? 9'd0 : nb[8:0];
        adj3_next.g = {1'b0, pix2_reg.g} + {3'b0, sh_g[5:0]};
        adj3_next.a = pix2_reg.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pix1_reg <= in_pix;
        wr1_reg  <= weight(in_pix.r);
        wg1_reg  <= weight(in_pix.g);
        wb1_reg  <= weight(in_pix.b);
        ts1_reg  <= ts;
        pix2_reg <= pix1_reg;
        pr2_reg  <= pr2_next;
        pg2_reg  <= pg2_next;
        pb2_reg  <= pb2_next;
        adj3_reg <= adj3_next;
    end

    assign out_valid = v3_reg;
    assign out_adj   = adj3_reg;

endmodule

`default_nettype wire

@@ design/ctp_recip.sv @@
// ----------------------------------------------------------------------------
// ctp_recip
// Stages 4-6: channel maximum, then 65280 / max as a restoring divider
// (divisor 256 when no channel exceeds 255), four quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_recip (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire ctp_pkg::ctp_adj_t  in_adj,
    output logic                    out_valid,
    output ctp_pkg::ctp_adj_t       out_adj,
    output ctp_pkg::ctp_rescale_t   out_rs
);
    import ctp_pkg::*;

    // stage 4
    logic             v4_reg, over4_reg;
    ctp_adj_t         adj4_reg;
    logic [ADJ_W-1:0] d4_reg;
    logic [ADJ_W-1:0] mx;
    logic             over4_next;

    // stage 5
    logic             v5_reg, over5_reg;
    ctp_adj_t         adj5_reg;
    logic [ADJ_W-1:0] d5_reg;
    logic [15:0]      rem5_reg;
    logic [3:0]       q5_reg;
    logic [16:0]      rem_a, trial_a;
    logic [3:0]       q_a;

    // stage 6
    logic         v6_reg;
    ctp_adj_t     adj6_reg;
    ctp_rescale_t rs6_reg;
    logic [16:0]  rem_b, trial_b;
    logic [3:0]   q_b;

    always_comb
    begin
        mx = in_adj.r;
        if (in_adj.g > mx)
            mx = in_adj.g;
        if (in_adj.b > mx)
            mx = in_adj.b;
        over4_next = (mx > ADJ_W'(CHAN_MAX));
    end

    always_comb
    begin
        rem_a   = 17'(FULL_SCALE);
        q_a     = 4'b0;
        trial_a = 17'b0;
        for (int i = 0; i < 4; i++)
        begin
            trial_a = {8'b0, d4_reg} << (7 - i);
            if (rem_a >= trial_a)
            begin
                rem_a      = rem_a - trial_a;
                q_a[3 - i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        rem_b   = {1'b0, rem5_reg};
        q_b     = 4'b0;
        trial_b = 17'b0;
        for (int i = 0; i < 4; i++)
        begin
            trial_b = {8'b0, d5_reg} << (3 - i);
            if (rem_b >= trial_b)
            begin
                rem_b      = rem_b - trial_b;
                q_b[3 - i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adj4_reg  <= in_adj;
        over4_reg <= over4_next;
        d4_reg    <= over4_next ? mx : ADJ_W'(WEIGHT_BASE);
        adj5_reg  <= adj4_reg;
        over5_reg <= over4_reg;
        d5_reg    <= d4_reg;
        rem5_reg  <= rem_a[15:0];
        q5_reg    <= q_a;
        adj6_reg  <= adj5_reg;
        rs6_reg   <= '{over: over5_reg, inv: {q5_reg, q_b}};
    end

    assign out_valid = v6_reg;
    assign out_adj   = adj6_reg;
    assign out_rs    = rs6_reg;

endmodule

`default_nettype wire

@@ design/ctp_scale.sv @@
// ----------------------------------------------------------------------------
// ctp_scale
// Stage 7: optional rescale by the reciprocal, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_scale (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire ctp_pkg::ctp_adj_t    in_adj,
    input  wire ctp_pkg::ctp_rescale_t in_rs,
    output logic                      out_valid,
    output ctp_pkg::ctp_pix_t         out_pix
);
    import ctp_pkg::*;

    logic        v7_reg;
    ctp_pix_t    pix7_reg;
    ctp_pix_t    pix7_next;
    logic [16:0] sr, sg, sb;

    always_comb
    begin
        sr = in_adj.r * in_rs.inv;
        sg = in_adj.g * in_rs.inv;
        sb = in_adj.b * in_rs.inv;
        pix7_next.r = in_rs.over ? sr[15:8] : in_adj.r[7:0];
        pix7_next.g = in_rs.over ? sg[15:8] : in_adj.g[7:0];
        pix7_next.b = in_rs.over ? sb[15:8] : in_adj.b[7:0];
        pix7_next.a = in_adj.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pix7_reg <= pix7_next;
    end

    assign out_valid = v7_reg;
    assign out_pix   = pix7_reg;

endmodule

`default_nettype wire

@@ design/color_temperature_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// color_temperature_pixel_unit
// Shifts the color temperature of one RGBA8 pixel per clock once out of reset.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel in: a transfer happens at each clock edge with start high and busy
//   low. busy is high only during reset and the first cycle after it, so a
//   new pixel may be taken every cycle.
//   Result: done is high for one cycle with out_red..out_alpha. A pixel taken
//   passes through 7 register stages before its result shows: weight,
//   product, add/clamp, max, two divider stages, rescale.
//   Throughput is one pixel per clock once busy is low; no stage holds off another.
//   The receiver cannot stall; results are never held back.
//   Config: cfg_data is written to temp_shift when cfg_valid and cfg_ready are
//   both high; write it only while no pixel is in flight.
//   Reset: empties the pipeline and sets temp_shift to 0; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_temperature_pixel_unit_assert.svh"

module color_temperature_pixel_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ctp_pkg::CHAN_W-1:0]         in_red,
    input  wire logic [ctp_pkg::CHAN_W-1:0]         in_green,
    input  wire logic [ctp_pkg::CHAN_W-1:0]         in_blue,
    input  wire logic [ctp_pkg::CHAN_W-1:0]         in_alpha,
    output logic                                    done,
    output logic [ctp_pkg::CHAN_W-1:0]              out_red,
    output logic [ctp_pkg::CHAN_W-1:0]              out_green,
    output logic [ctp_pkg::CHAN_W-1:0]              out_blue,
    output logic [ctp_pkg::CHAN_W-1:0]              out_alpha,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic signed [ctp_pkg::SHIFT_W-1:0] cfg_data
);
    import ctp_pkg::*;

    logic                      busy_reg;
    logic signed [SHIFT_W-1:0] temp_shift_reg;
    logic                      accept;
    ctp_pix_t                  in_pix;

    logic         adj_valid, rcp_valid;
    ctp_adj_t     adj, rcp_adj;
    ctp_rescale_t rcp_rs;
    ctp_pix_t     res_pix;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign in_pix    = '{r: in_red, g: in_green, b: in_blue, a: in_alpha};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            temp_shift_reg <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                temp_shift_reg <= cfg_data;
        end
    end

    ctp_adjust u_adjust (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_pix    (in_pix),
        .ts        (temp_shift_reg),
        .out_valid (adj_valid),
        .out_adj   (adj)
    );

    ctp_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (adj_valid),
        .in_adj    (adj),
        .out_valid (rcp_valid),
        .out_adj   (rcp_adj),
        .out_rs    (rcp_rs)
    );

    ctp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rcp_valid),
        .in_adj    (rcp_adj),
        .in_rs     (rcp_rs),
        .out_valid (done),
        .out_pix   (res_pix)
    );

    assign out_red   = res_pix.r;
    assign out_green = res_pix.g;
    assign out_blue  = res_pix.b;
    assign out_alpha = res_pix.a;

    `CTP_ASSERT_DELAY(a_latency, start && !busy, 7, done, "transfer without result")
    `CTP_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, 7), "result without transfer")
    `CTP_ASSERT_IMPLY(a_alpha_align, done, out_alpha == $past(in_alpha, 7), "alpha misaligned")
    `CTP_ASSERT_IMPLY(a_rescale_range, rcp_valid && rcp_rs.over, rcp_rs.inv[7] == 1'b1,
                      "reciprocal out of range")

endmodule

`default_nettype wire

@@ tb/color_temperature_pixel_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_temperature_pixel_unit_tb
// Drives RGBA8 pixels through the unit under a series of temp_shift settings.
// The settings include the reset value, the stated extremes and the full
// register range. Results are checked against a directed case's stated value
// or else a local model of the warm/cool shift and the overflow rescale.
// ----------------------------------------------------------------------------

module color_temperature_pixel_unit_tb;

    import ctp_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PIPE_DEPTH   = 7;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_PIXELS = 66;
    localparam int NUM_DIRECTED = 23;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = 9'h100;
    localparam logic signed [SHIFT_W-1:0] SHIFT_TOP = 9'h0FF;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift;
        ctp_pix_t                  px;
        logic                      known;
        ctp_pix_t                  want;
    } pixel_case_t;

    localparam pixel_case_t DIRECTED_CASES [NUM_DIRECTED] = '{
        // reset value: identity
        '{9'sd0, '{8'd12, 8'd34, 8'd56, 8'd78}, 1'b1, '{8'd12, 8'd34, 8'd56, 8'd78}},
        '{9'sd0, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{9'sd0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{9'sd0, '{8'd128, 8'd128, 8'd128, 8'd200}, 1'b1,
          '{8'd128, 8'd128, 8'd128, 8'd200}},
        // warmest stated setting
        '{9'sd128, '{8'd0, 8'd0, 8'd0, 8'hA5}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'hA5}},
        '{9'sd128, '{8'd255, 8'd255, 8'd255, 8'h5A}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'h5A}},
        '{9'sd128, '{8'd128, 8'd128, 8'd128, 8'd1}, 1'b0, '0},
        '{9'sd128, '{8'd200, 8'd100, 8'd50, 8'd255}, 1'b0, '0},
        '{9'sd128, '{8'd250, 8'd10, 8'd128, 8'd0}, 1'b0, '0},
        // coolest stated setting
        '{-9'sd128, '{8'd0, 8'd255, 8'd0, 8'h3C}, 1'b1, '{8'd0, 8'd255, 8'd0, 8'h3C}},
        '{-9'sd128, '{8'd128, 8'd128, 8'd128, 8'd77}, 1'b0, '0},
        '{-9'sd128, '{8'd30, 8'd60, 8'd90, 8'd120}, 1'b0, '0},
        // large shift, overflow and rescale
        '{SHIFT_TOP, '{8'd140, 8'd128, 8'd10, 8'd9}, 1'b0, '0},
        '{SHIFT_TOP, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{SHIFT_TOP, '{8'd128, 8'd128, 8'd128, 8'd0}, 1'b0, '0},
        // most negative shift, red clamps at zero, blue overflows
        '{SHIFT_MIN, '{8'd128, 8'd0, 8'd128, 8'd44}, 1'b0, '0},
        '{SHIFT_MIN, '{8'd100, 8'd200, 8'd1, 8'd2}, 1'b0, '0},
        '{SHIFT_MIN, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        // rounding toward minus infinity at the smallest steps
        '{9'sd1, '{8'd128, 8'd128, 8'd128, 8'd128}, 1'b0, '0},
        '{9'sd1, '{8'd1, 8'd1, 8'd1, 8'd1}, 1'b0, '0},
        '{-9'sd1, '{8'd128, 8'd128, 8'd128, 8'd128}, 1'b0, '0},
        '{-9'sd1, '{8'd3, 8'd250, 8'd7, 8'd9}, 1'b0, '0},
        '{-9'sd1, '{8'd255, 8'd0, 8'd254, 8'd170}, 1'b0, '0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CHAN_W-1:0]         in_red;
    logic [CHAN_W-1:0]         in_green;
    logic [CHAN_W-1:0]         in_blue;
    logic [CHAN_W-1:0]         in_alpha;
    logic                      done;
    logic [CHAN_W-1:0]         out_red;
    logic [CHAN_W-1:0]         out_green;
    logic [CHAN_W-1:0]         out_blue;
    logic [CHAN_W-1:0]         out_alpha;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic signed [SHIFT_W-1:0] cfg_data;

    logic signed [SHIFT_W-1:0] shift_setting;
    ctp_pix_t                  pending_pixels[$];
    ctp_pix_t                  head_pixel;
    int                        mismatch_count;
    int                        pixels_sent;
    int                        pixels_checked;
    int                        shift_writes;
    int                        cycle_count;

    color_temperature_pixel_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int tone_weight(input logic [CHAN_W-1:0] c);
        return int'(c) * (WEIGHT_BASE - int'(c));
    endfunction

    function automatic ctp_pix_t shift_temperature(input ctp_pix_t px,
                                                   input logic signed [SHIFT_W-1:0] ts);
        int       t;
        int       gs;
        int       nr;
        int       ng;
        int       nb;
        int       mx;
        int       inv;
        ctp_pix_t res;
        t  = ts;
        gs = (t > 0) ? t : 0;
        nr = int'(px.r) + ((tone_weight(px.r) * t) >>> RB_SHIFT);
        ng = int'(px.g) + ((tone_weight(px.g) * gs) >>> G_SHIFT);
        nb = int'(px.b) - ((tone_weight(px.b) * t) >>> RB_SHIFT);
        if (nr < 0) nr = 0;
        if (ng < 0) ng = 0;
        if (nb < 0) nb = 0;
        mx = nr;
        if (ng > mx) mx = ng;
        if (nb > mx) mx = nb;
        if (mx > CHAN_MAX)
        begin
            inv = FULL_SCALE / mx;
            nr  = (nr * inv) >> 8;
            ng  = (ng * inv) >> 8;
            nb  = (nb * inv) >> 8;
        end
        res.r = nr[CHAN_W-1:0];
        res.g = ng[CHAN_W-1:0];
        res.b = nb[CHAN_W-1:0];
        res.a = px.a;
        return res;
    endfunction

    // mostly uniform, with a bias toward 0, 1, 128 and 255
    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'd0;
                1:       return 8'd255;
                2:       return 8'd128;
                default: return 8'd1;
            endcase
        end
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input ctp_pix_t px, input logic known, input ctp_pix_t want);
        start    <= 1'b1;
        in_red   <= px.r;
        in_green <= px.g;
        in_blue  <= px.b;
        in_alpha <= px.a;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_pixels.push_back(known ? want : shift_temperature(px, shift_setting));
        pixels_sent++;
    endtask

    task automatic drain_pixels();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_shift(input logic signed [SHIFT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid     <= 1'b0;
        shift_setting  = value;
        shift_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("[%0t] unexpected result %0d %0d %0d %0d", $realtime,
                             out_red, out_green, out_blue, out_alpha);
                mismatch_count++;
            end
            else
            begin
                head_pixel = pending_pixels.pop_front();
                pixels_checked++;
                if (out_red !== head_pixel.r || out_green !== head_pixel.g ||
                    out_blue !== head_pixel.b || out_alpha !== head_pixel.a)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("[%0t] rgba mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 $realtime, head_pixel.r, head_pixel.g, head_pixel.b,
                                 head_pixel.a, out_red, out_green, out_blue, out_alpha);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                        row;
        int                        phase;
        int                        n;
        logic                      last_phase;
        logic signed [SHIFT_W-1:0] next_shift;
        ctp_pix_t                  px;

        rst_n          = 1'b0;
        start          = 1'b0;
        in_red         = '0;
        in_green       = '0;
        in_blue        = '0;
        in_alpha       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        shift_setting  = '0;
        mismatch_count = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        shift_writes   = 0;
        cycle_count    = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < NUM_DIRECTED; row++)
        begin
            if (DIRECTED_CASES[row].shift !== shift_setting)
            begin
                drain_pixels();
                write_shift(DIRECTED_CASES[row].shift);
            end
            send_pixel(DIRECTED_CASES[row].px, DIRECTED_CASES[row].known,
                       DIRECTED_CASES[row].want);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       next_shift = 9'sd128;
                1:       next_shift = -9'sd128;
                2:       next_shift = 9'sd0;
                3:       next_shift = SHIFT_TOP;
                4:       next_shift = SHIFT_MIN;
                5, 7:    next_shift = SHIFT_W'($urandom_range(0, 256)) - 9'sd128;
                default: next_shift = SHIFT_W'($urandom_range(0, 511));
            endcase
            // every result is back before the register changes
            drain_pixels();
            write_shift(next_shift);
            last_phase = (phase == NUM_PHASES - 1);
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                if (!last_phase && $urandom_range(0, 4) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge clk);
                end
                px.r = pick_channel();
                px.g = pick_channel();
                px.b = pick_channel();
                px.a = CHAN_W'($urandom_range(0, 255));
                send_pixel(px, 1'b0, '0);
            end
        end

        drain_pixels();
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("%0d pixels sent and %0d results checked over %0d temp_shift writes",
                 pixels_sent, pixels_checked, shift_writes);
        $display("settings covered: reset value, +/-128, -256, 255 and random values; %0d errors",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
